/* sv/ecd_pkg.sv */
// ecd_pkg: constants and month table for the epoch-seconds to calendar-date converter.
// No dependencies; used by ecd_month_find and epoch_seconds_to_calendar_date.
package ecd_pkg;

	localparam int unsigned EpochYear = 1970;

	// Reciprocal multipliers, each floor(2^k / d); the quotient estimate is low by at most one.
	localparam int unsigned DivDayK    = 35;                  // (seconds >> 7) / 675
	localparam int unsigned MulDay     = 50903316;
	localparam int unsigned DayOdd     = 675;                 // 86400 = 675 << 7
	localparam int unsigned DivQuadK   = 27;                  // days / 1461
	localparam int unsigned MulQuad    = 91867;
	localparam int unsigned DaysQuad   = 1461;
	localparam int unsigned DivMinK    = 23;                  // second of day / 60
	localparam int unsigned MulMin     = 139810;
	localparam int unsigned DivHourK   = 17;                  // minute of day / 60
	localparam int unsigned MulHour    = 2184;
	localparam int unsigned SixtyC     = 60;

	// Day-of-quad starts of the years in a quad beginning at 1970 (third year is leap).
	localparam int unsigned Year1Start = 365;
	localparam int unsigned Year2Start = 730;
	localparam int unsigned Year3Start = 1096;

	localparam int unsigned NumMonths  = 12;

	// First day of year (0-based) of month m (0 = January).
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		unique case (m)
			4'd0: s = 9'd0;
			4'd1: s = 9'd31;
			4'd2: s = 9'd59;
			4'd3: s = 9'd90;
			4'd4: s = 9'd120;
			4'd5: s = 9'd151;
			4'd6: s = 9'd181;
			4'd7: s = 9'd212;
			4'd8: s = 9'd243;
			4'd9: s = 9'd273;
			4'd10: s = 9'd304;
			4'd11: s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && m >= 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

/* sv/ecd_month_find.sv */
// ecd_month_find: splits a 0-based day of year into month index and day within month.
// Depends on ecd_pkg (month_start).
module ecd_month_find (
	input  logic [8:0] doy,
	input  logic       leap,
	output logic [3:0] month_idx,
	output logic [4:0] day_idx
);

	logic [8:0] start_sel;
	logic [8:0] day_full;

	always_comb begin
		month_idx = 4'd0;
		for (int i = 1; i < ecd_pkg::NumMonths; i++) begin
			if (doy >= ecd_pkg::month_start(4'(i), leap)) begin
				month_idx = 4'(i);
			end
		end
		start_sel = ecd_pkg::month_start(month_idx, leap);
		day_full  = doy - start_sel;
		day_idx   = day_full[4:0];
	end

endmodule

/* sv/epoch_seconds_to_calendar_date.sv */
// epoch_seconds_to_calendar_date: unsigned seconds since 1970-01-01 to year, month, day, hour, minute.
// Depends on ecd_pkg and ecd_month_find.
//
// channel  | handshake             | payload
// request  | req_valid / req_ready | seconds[31:0]
// result   | res_valid / res_ready | year[11:0] month[3:0] day_of_month[4:0] hour[4:0] minute[5:0]
//
// Nine register stages; one beat may enter every cycle unless the pipe is stalled.
// Divisions by constants are reciprocal multiplies with one correction stage each.
// The whole pipe advances together when the output register is empty or being taken,
// so a stall holds every stage in place.
// Reset clears all stage valids and res_valid.
module epoch_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [31:0] seconds,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute
);

	logic       adv;
	logic [8:1] vld_q;

	// stage 1
	logic [50:0] prod1;
	logic [15:0] qd_s1;
	logic [24:0] x25_s1;
	logic [6:0]  lo7_s1;
	// stage 2
	logic [25:0] p2;
	logic [25:0] diff2;
	logic [15:0] qd_s2;
	logic [10:0] r_s2;
	logic [6:0]  lo7_s2;
	// stage 3
	logic [10:0] r3;
	logic [15:0] days_s3;
	logic [16:0] sod_s3;
	// stage 4
	logic [32:0] prodq;
	logic [33:0] prodm;
	logic [15:0] days_s4;
	logic [16:0] sod_s4;
	logic [5:0]  q4_s4;
	logic [10:0] mod_s4;
	// stage 5
	logic [15:0] pq5;
	logic [15:0] dq5;
	logic [16:0] pm5;
	logic [16:0] dm5;
	logic [5:0]  q4_s5;
	logic [11:0] r4_s5;
	logic [10:0] mod_s5;
	logic [6:0]  rm_s5;
	// stage 6
	logic [11:0] r6;
	logic [5:0]  q4_s6;
	logic [10:0] d4_s6;
	logic [10:0] mod_s6;
	// stage 7
	logic [1:0]  off7;
	logic [10:0] doy7;
	logic [22:0] prodh;
	logic [11:0] year_s7;
	logic [8:0]  doy_s7;
	logic        leap_s7;
	logic [10:0] mod_s7;
	logic [4:0]  hre_s7;
	// stage 8
	logic [3:0]  mon8;
	logic [4:0]  day8;
	logic [10:0] ph8;
	logic [10:0] dh8;
	logic [11:0] year_s8;
	logic [3:0]  mon_s8;
	logic [4:0]  day_s8;
	logic [4:0]  hre_s8;
	logic [6:0]  rh_s8;

	assign adv       = !res_valid || res_ready;
	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			res_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[7:1], req_valid};
			res_valid <= vld_q[8];
		end
	end

	always_comb begin
		prod1 = 51'(seconds[31:7]) * 51'(ecd_pkg::MulDay);
		p2    = 26'(qd_s1) * 26'(ecd_pkg::DayOdd);
		diff2 = 26'(x25_s1) - p2;
		r3    = r_s2 - 11'(ecd_pkg::DayOdd);
		prodq = 33'(days_s3) * 33'(ecd_pkg::MulQuad);
		prodm = 34'(sod_s3) * 34'(ecd_pkg::MulMin);
		pq5   = 16'(q4_s4) * 16'(ecd_pkg::DaysQuad);
		dq5   = days_s4 - pq5;
		pm5   = 17'(mod_s4) * 17'(ecd_pkg::SixtyC);
		dm5   = sod_s4 - pm5;
		r6    = r4_s5 - 12'(ecd_pkg::DaysQuad);
		prodh = 23'(mod_s6) * 23'(ecd_pkg::MulHour);
		if (d4_s6 < 11'(ecd_pkg::Year1Start)) begin
			off7 = 2'd0;
			doy7 = d4_s6;
		end else if (d4_s6 < 11'(ecd_pkg::Year2Start)) begin
			off7 = 2'd1;
			doy7 = d4_s6 - 11'(ecd_pkg::Year1Start);
		end else if (d4_s6 < 11'(ecd_pkg::Year3Start)) begin
			off7 = 2'd2;
			doy7 = d4_s6 - 11'(ecd_pkg::Year2Start);
		end else begin
			off7 = 2'd3;
			doy7 = d4_s6 - 11'(ecd_pkg::Year3Start);
		end
		ph8 = 11'(hre_s7) * 11'(ecd_pkg::SixtyC);
		dh8 = mod_s7 - ph8;
	end

	ecd_month_find u_month (
		.doy       (doy_s7),
		.leap      (leap_s7),
		.month_idx (mon8),
		.day_idx   (day8)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: day quotient estimate
			qd_s1  <= prod1[50:35];
			x25_s1 <= seconds[31:7];
			lo7_s1 <= seconds[6:0];
			// s2: remainder of estimate
			qd_s2  <= qd_s1;
			r_s2   <= diff2[10:0];
			lo7_s2 <= lo7_s1;
			// s3: correct days, rebuild second of day
			if (r_s2 >= 11'(ecd_pkg::DayOdd)) begin
				days_s3 <= qd_s2 + 16'd1;
				sod_s3  <= {r3[9:0], lo7_s2};
			end else begin
				days_s3 <= qd_s2;
				sod_s3  <= {r_s2[9:0], lo7_s2};
			end
			// s4: quad and minute-of-day estimates
			days_s4 <= days_s3;
			sod_s4  <= sod_s3;
			q4_s4   <= prodq[32:27];
			mod_s4  <= prodm[33:23];
			// s5: remainders
			q4_s5  <= q4_s4;
			r4_s5  <= dq5[11:0];
			mod_s5 <= mod_s4;
			rm_s5  <= dm5[6:0];
			// s6: corrections
			if (r4_s5 >= 12'(ecd_pkg::DaysQuad)) begin
				q4_s6 <= q4_s5 + 6'd1;
				d4_s6 <= r6[10:0];
			end else begin
				q4_s6 <= q4_s5;
				d4_s6 <= r4_s5[10:0];
			end
			if (rm_s5 >= 7'(ecd_pkg::SixtyC)) begin
				mod_s6 <= mod_s5 + 11'd1;
			end else begin
				mod_s6 <= mod_s5;
			end
			// s7: year within quad, hour estimate
			year_s7 <= 12'(ecd_pkg::EpochYear) + 12'({q4_s6, 2'b00}) + 12'(off7);
			doy_s7  <= doy7[8:0];
			leap_s7 <= (off7 == 2'd2);
			mod_s7  <= mod_s6;
			hre_s7  <= prodh[21:17];
			// s8: month split, minute remainder
			year_s8 <= year_s7;
			mon_s8  <= mon8;
			day_s8  <= day8;
			hre_s8  <= hre_s7;
			rh_s8   <= dh8[6:0];
			// output register
			year         <= year_s8;
			month        <= mon_s8 + 4'd1;
			day_of_month <= day_s8 + 5'd1;
			if (rh_s8 >= 7'(ecd_pkg::SixtyC)) begin
				hour   <= hre_s8 + 5'd1;
				minute <= 6'(rh_s8 - 7'(ecd_pkg::SixtyC));
			end else begin
				hour   <= hre_s8;
				minute <= rh_s8[5:0];
			end
		end
	end

endmodule

/* tb/sv/epoch_seconds_to_calendar_date_tb.sv */
`timescale 1ns / 1ps
// epoch_seconds_to_calendar_date_tb: self-checking bench for the seconds-to-date converter.
// Directed table then random beats under four idle/stall mixes; results checked in order.
// Depends on ecd_pkg and epoch_seconds_to_calendar_date.
module epoch_seconds_to_calendar_date_tb;

	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerDay  = 86400;
	localparam int          WatchdogLimit = 2000;
	localparam int          PhaseBeats    = 150;
	localparam int          SqueezeCycles = 80;
	localparam int          NumDirected   = 24;
	localparam logic [31:0] Feb29Of2100   = 32'd4107542400;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} cal_date_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        fixed;
		cal_date_t   want;
	} dir_row_t;

	// fixed rows carry their date; the rest go through the predictor
	localparam dir_row_t DirTable [NumDirected] = '{
		'{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0}},
		'{32'd59,         1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0}},
		'{32'd60,         1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd86400,      1'b0, '0},
		'{32'd2678399,    1'b0, '0},
		'{32'd5097600,    1'b0, '0},
		'{32'd31535999,   1'b0, '0},
		'{32'd31536000,   1'b1, '{12'd1971, 4'd1, 5'd1, 5'd0, 6'd0}},
		'{32'd68169600,   1'b0, '0},
		'{32'd68256000,   1'b0, '0},
		'{32'd94694399,   1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'h5555_5555,  1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0},
		'{32'h7FFF_FFFF,  1'b0, '0},
		'{32'h8000_0000,  1'b0, '0},
		'{32'd4107542399, 1'b0, '0},
		'{32'd4107542400, 1'b1, '{12'd2100, 4'd2, 5'd29, 5'd0, 6'd0}},
		'{32'd4107628800, 1'b0, '0},
		'{32'd4134067199, 1'b0, '0},
		'{32'd4134067200, 1'b0, '0},
		'{32'd4291833600, 1'b0, '0},
		'{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd6, 5'd6, 6'd28}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [31:0] seconds = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;

	cal_date_t pending_dates [$];
	int        errors = 0;
	int        stall_cycles = 0;
	int        hold_cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	epoch_seconds_to_calendar_date dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.seconds      (seconds),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// every fourth year is leap, 2100 included
	function automatic cal_date_t civil_from_seconds(input logic [31:0] secs);
		cal_date_t   d;
		longint      left;
		int unsigned yr;
		int unsigned span;
		int unsigned day_idx;
		int unsigned mon;
		int unsigned mlen;
		bit          done;
		left = longint'(secs);
		yr = ecd_pkg::EpochYear;
		span = ((yr % 4) == 0) ? 366 * SecsPerDay : 365 * SecsPerDay;
		while (left >= span) begin
			left -= span;
			yr++;
			span = ((yr % 4) == 0) ? 366 * SecsPerDay : 365 * SecsPerDay;
		end
		day_idx = 32'(left / SecsPerDay);
		left = left % SecsPerDay;
		d.hour = 5'(left / SecsPerHour);
		d.minute = 6'((left % SecsPerHour) / SecsPerMin);
		mon = 0;
		done = 1'b0;
		while (!done) begin
			case (mon)
				1: mlen = ((yr % 4) == 0) ? 29 : 28;
				3, 5, 8, 10: mlen = 30;
				default: mlen = 31;
			endcase
			if (day_idx < mlen || mon == 11) begin
				done = 1'b1;
			end else begin
				day_idx -= mlen;
				mon++;
			end
		end
		d.year = 12'(yr);
		d.month = 4'(mon + 1);
		d.day = 5'(day_idx + 1);
		return d;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: mismatch on %s, got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic offer_seconds(input logic [31:0] secs, input bit fixed,
			input cal_date_t fixed_want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		seconds = secs;
		forever begin
			@(posedge clk);
			if (req_ready === 1'b1) break;
			@(negedge clk);
		end
		pending_dates.push_back(fixed ? fixed_want : civil_from_seconds(secs));
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input bit squeeze);
		int          kind;
		int unsigned yr;
		int unsigned y;
		longint      wide;
		longint      ofs;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (squeeze) hold_cycles = SqueezeCycles;
		for (int i = 0; i < PhaseBeats; i++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				wide = $urandom;
			end else if (kind <= 6) begin
				// around midnight
				ofs = $urandom_range(0, 120);
				wide = longint'($urandom_range(0, 49710)) * SecsPerDay + ofs - 60;
			end else if (kind <= 8) begin
				// around new year
				yr = $urandom_range(ecd_pkg::EpochYear, 2106);
				wide = 0;
				for (y = ecd_pkg::EpochYear; y < yr; y++) begin
					wide += ((y % 4) == 0) ? 366 * SecsPerDay : 365 * SecsPerDay;
				end
				ofs = $urandom_range(0, 7200);
				wide += ofs - 3600;
			end else begin
				// weeks either side of the 2100 leap day
				ofs = $urandom_range(0, 80 * SecsPerDay);
				wide = longint'(Feb29Of2100) + ofs - 40 * SecsPerDay;
			end
			offer_seconds(wide[31:0], 1'b0, '0);
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			res_ready = 1'b0;
			hold_cycles--;
		end else begin
			res_ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cal_date_t want;
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_dates.pop_front();
				if (year !== want.year)
					report_mismatch("year", 32'(year), 32'(want.year));
				if (month !== want.month)
					report_mismatch("month", 32'(month), 32'(want.month));
				if (day_of_month !== want.day)
					report_mismatch("day_of_month", 32'(day_of_month), 32'(want.day));
				if (hour !== want.hour)
					report_mismatch("hour", 32'(hour), 32'(want.hour));
				if (minute !== want.minute)
					report_mismatch("minute", 32'(minute), 32'(want.minute));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready === 1'b1) || (res_valid === 1'b1 && res_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WatchdogLimit) begin
			$display("epoch_seconds_to_calendar_date_tb: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < NumDirected; i++) begin
			offer_seconds(DirTable[i].secs, DirTable[i].fixed, DirTable[i].want);
		end
		run_phase(0, 0, 1'b1);
		run_phase(67, 0, 1'b0);
		run_phase(0, 67, 1'b1);
		run_phase(9, 9, 1'b0);
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0) begin
			$display("epoch_seconds_to_calendar_date_tb: done, clean");
		end else begin
			$display("epoch_seconds_to_calendar_date_tb: done, errors");
		end
		$finish;
	end

endmodule
